FILE: design/lgi_pkg.sv
`timescale 1ns / 1ps

package lgi_pkg;

   // Node count, limited to what the node table holds and at least two.
   localparam int NUM_NODES   = 13;
   localparam int TABLE_NODES = 13;
   localparam int NODE_COUNT  = (NUM_NODES > TABLE_NODES) ? TABLE_NODES :
                                ((NUM_NODES < 2) ? 2 : NUM_NODES);
   localparam int IDX_W       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam int CNT_W       = $clog2(NODE_COUNT + 1);

   // Width of the working significand inside the arithmetic unit.
   localparam int SIG_W = 106;

   localparam logic [63:0] ONE_BITS    = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;

   // Exact conversion of a small unsigned integer into a double.
   function automatic logic [63:0] int_to_double(input logic [15:0] v);
      logic [5:0]  msb;
      logic [63:0] m;
      msb = 6'd0;
      for (int b = 0; b < 16; b++) begin
         if (v[b]) begin
            msb = 6'(b);
         end
      end
      m = 64'(v) << (6'd52 - msb);
      if (v == 16'd0) begin
         return 64'd0;
      end
      return {1'b0, 11'd1023 + 11'(msb), m[51:0]};
   endfunction

   // Abscissae are held in hundredths; each is divided by one hundred at
   // start-up, which rounds exactly as the decimal literal does.
   localparam logic [63:0] HUNDRED_BITS = int_to_double(16'd100);

   localparam logic [63:0] NODE_XC_BITS [TABLE_NODES] = '{
      int_to_double(16'd0),    int_to_double(16'd500),  int_to_double(16'd1000),
      int_to_double(16'd2024), int_to_double(16'd2646), int_to_double(16'd3550),
      int_to_double(16'd4507), int_to_double(16'd5833), int_to_double(16'd6789),
      int_to_double(16'd7487), int_to_double(16'd8003), int_to_double(16'd8387),
      int_to_double(16'd8678)
   };

   localparam logic [63:0] NODE_Y_BITS [TABLE_NODES] = '{
      int_to_double(16'd0),   int_to_double(16'd15),  int_to_double(16'd58),
      int_to_double(16'd171), int_to_double(16'd181), int_to_double(16'd220),
      int_to_double(16'd269), int_to_double(16'd318), int_to_double(16'd377),
      int_to_double(16'd406), int_to_double(16'd436), int_to_double(16'd441),
      int_to_double(16'd446)
   };

   typedef enum logic [1:0] {
      FOP_ADD,
      FOP_SUB,
      FOP_MUL,
      FOP_DIV
   } fpu_op_type;

   typedef struct packed {
      logic       start;
      fpu_op_type op;
      logic [63:0] a;
      logic [63:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } fpu_rsp_type;

   typedef enum logic [3:0] {
      F_IDLE,
      F_ALIGN,
      F_MUL,
      F_DNORM,
      F_DIV,
      F_NORM,
      F_SHIFT,
      F_ROUND,
      F_DONE
   } fpu_state_type;

   typedef enum logic [3:0] {
      S_INIT_X,
      S_DEN_XI,
      S_DEN_SUB,
      S_DEN_MUL,
      S_IDLE,
      S_RUN_START,
      S_RUN_SUB,
      S_RUN_MUL,
      S_RUN_DIV,
      S_RUN_WY,
      S_RUN_ACC,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic               sign;
      logic signed [13:0] expo;
      logic [52:0]        mant;
   } unpacked_type;

   // Value is mant * 2^(expo - 52).
   function automatic unpacked_type unpack(input logic [63:0] x);
      unpacked_type u;
      u.sign = x[63];
      if (x[62:52] == 11'd0) begin
         u.expo = -14'sd1022;
         u.mant = {1'b0, x[51:0]};
      end else begin
         u.expo = $signed({3'b000, x[62:52]}) - 14'sd1023;
         u.mant = {1'b1, x[51:0]};
      end
      return u;
   endfunction

endpackage

FILE: design/lgi_fpu.sv
`timescale 1ns / 1ps

module lgi_fpu import lgi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fpu_req_type req,
   output fpu_rsp_type rsp
);

   fpu_state_type      state_ff, state_in;
   logic               sign_ff, sign_in;
   logic               effsub_ff, effsub_in;
   logic signed [13:0] exp_ff, exp_in;
   logic signed [13:0] ea_ff, ea_in;
   logic signed [13:0] eb_ff, eb_in;
   logic [52:0]        ma_ff, ma_in;
   logic [52:0]        mb_ff, mb_in;
   logic [SIG_W-1:0]   sig_ff, sig_in;
   logic               sticky_ff, sticky_in;
   logic [53:0]        rem_ff, rem_in;
   logic [55:0]        quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [63:0]        res_ff, res_in;

   unpacked_type       ua, ub;
   logic [63:0]        b_eff;
   logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, s_x;
   logic               swap;

   logic signed [13:0] d_exp;
   logic [55:0]        ext_small, sh_small;
   logic [56:0]        big57, small57, sum57;
   logic               lost_add;

   logic [26:0]        pa, pb;
   logic [53:0]        pp;
   logic [SIG_W-1:0]   pp_shifted;

   logic [53:0]        rem_diff;
   logic               qbit;

   logic signed [13:0] shamt;
   logic [52:0]        m_r;
   logic [53:0]        m_up;
   logic               g_r, st_r, up_r;
   logic signed [13:0] exp_r, ef_r;
   logic [51:0]        frac_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sign_ff   <= sign_in;
      effsub_ff <= effsub_in;
      exp_ff    <= exp_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      sig_ff    <= sig_in;
      sticky_ff <= sticky_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      sign_in   = sign_ff;
      effsub_in = effsub_ff;
      exp_in    = exp_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      sig_in    = sig_ff;
      sticky_in = sticky_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      res_in    = res_ff;

      // Operand decode.
      b_eff  = (req.op == FOP_SUB) ? {~req.b[63], req.b[62:0]} : req.b;
      ua     = unpack(req.a);
      ub     = unpack(b_eff);
      nan_a  = (req.a[62:52] == 11'h7FF) && (req.a[51:0] != 52'd0);
      nan_b  = (req.b[62:52] == 11'h7FF) && (req.b[51:0] != 52'd0);
      inf_a  = (req.a[62:52] == 11'h7FF) && (req.a[51:0] == 52'd0);
      inf_b  = (req.b[62:52] == 11'h7FF) && (req.b[51:0] == 52'd0);
      zero_a = (req.a[62:0] == 63'd0);
      zero_b = (req.b[62:0] == 63'd0);
      s_x    = ua.sign ^ ub.sign;
      swap   = (req.a[62:0] < b_eff[62:0]);

      // Addition alignment with guard, round and sticky bits.
      d_exp     = ea_ff - eb_ff;
      ext_small = {mb_ff, 3'b000};
      sh_small  = ext_small >> d_exp[5:0];
      if (d_exp >= 14'sd56) begin
         lost_add = (mb_ff != 53'd0);
         small57  = {56'd0, lost_add};
      end else begin
         lost_add = |(ext_small & ~({56{1'b1}} << d_exp[5:0]));
         small57  = {1'b0, sh_small[55:1], sh_small[0] | lost_add};
      end
      big57 = {1'b0, ma_ff, 3'b000};
      sum57 = effsub_ff ? (big57 - small57) : (big57 + small57);

      // One partial product of the significand multiply.
      pa = cnt_ff[1] ? {1'b0, ma_ff[52:27]} : ma_ff[26:0];
      pb = cnt_ff[0] ? {1'b0, mb_ff[52:27]} : mb_ff[26:0];
      pp = {27'd0, pa} * {27'd0, pb};
      case ({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]})
         2'd0:    pp_shifted = {52'd0, pp};
         2'd1:    pp_shifted = {52'd0, pp} << 27;
         default: pp_shifted = {52'd0, pp} << 54;
      endcase

      // One restoring division step.
      rem_diff = rem_ff - {1'b0, mb_ff};
      qbit     = (rem_ff >= {1'b0, mb_ff});

      // Rounding to nearest even.
      shamt  = (-14'sd1022) - exp_ff;
      m_r    = sig_ff[SIG_W-1 -: 53];
      g_r    = sig_ff[SIG_W-54];
      st_r   = sticky_ff | (|sig_ff[SIG_W-55:0]);
      up_r   = g_r & (st_r | m_r[0]);
      m_up   = {1'b0, m_r} + {53'd0, up_r};
      if (m_up[53]) begin
         exp_r  = exp_ff + 14'sd1;
         frac_r = 52'd0;
      end else begin
         exp_r  = exp_ff;
         frac_r = m_up[51:0];
      end
      ef_r = exp_r + 14'sd1023;

      unique case (state_ff)
         F_IDLE: begin
            if (req.start) begin
               sig_in    = '0;
               sticky_in = 1'b0;
               cnt_in    = 6'd0;
               state_in  = F_DONE;
               if (nan_a) begin
                  res_in = req.a | QUIET_BIT;
               end else if (nan_b) begin
                  res_in = req.b | QUIET_BIT;
               end else begin
                  case (req.op) inside
                     FOP_ADD, FOP_SUB: begin
                        if (inf_a && inf_b && (ua.sign != ub.sign)) begin
                           res_in = DEFAULT_NAN;
                        end else if (inf_a) begin
                           res_in = req.a;
                        end else if (inf_b) begin
                           res_in = b_eff;
                        end else begin
                           effsub_in = s_x;
                           if (swap) begin
                              sign_in = ub.sign;
                              ma_in   = ub.mant;
                              ea_in   = ub.expo;
                              mb_in   = ua.mant;
                              eb_in   = ua.expo;
                           end else begin
                              sign_in = ua.sign;
                              ma_in   = ua.mant;
                              ea_in   = ua.expo;
                              mb_in   = ub.mant;
                              eb_in   = ub.expo;
                           end
                           state_in = F_ALIGN;
                        end
                     end
                     FOP_MUL: begin
                        if ((inf_a && zero_b) || (zero_a && inf_b)) begin
                           res_in = DEFAULT_NAN;
                        end else if (inf_a || inf_b) begin
                           res_in = {s_x, 11'h7FF, 52'd0};
                        end else begin
                           sign_in  = s_x;
                           ma_in    = ua.mant;
                           mb_in    = ub.mant;
                           exp_in   = ua.expo + ub.expo + 14'sd1;
                           state_in = F_MUL;
                        end
                     end
                     default: begin
                        if ((inf_a && inf_b) || (zero_a && zero_b)) begin
                           res_in = DEFAULT_NAN;
                        end else if (inf_a || zero_b) begin
                           res_in = {s_x, 11'h7FF, 52'd0};
                        end else if (inf_b || zero_a) begin
                           res_in = {s_x, 63'd0};
                        end else begin
                           sign_in  = s_x;
                           ma_in    = ua.mant;
                           mb_in    = ub.mant;
                           ea_in    = ua.expo;
                           eb_in    = ub.expo;
                           state_in = F_DNORM;
                        end
                     end
                  endcase
               end
            end
         end
         F_ALIGN: begin
            sig_in = {sum57, {(SIG_W-57){1'b0}}};
            exp_in = ea_ff + 14'sd1;
            if (sum57 == 57'd0) begin
               sign_in = effsub_ff ? 1'b0 : sign_ff;
            end
            state_in = F_NORM;
         end
         F_MUL: begin
            sig_in = sig_ff + pp_shifted;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = F_NORM;
            end
         end
         F_DNORM: begin
            // Subnormal operands are brought to a leading one first.
            if (!ma_ff[52]) begin
               ma_in = {ma_ff[51:0], 1'b0};
               ea_in = ea_ff - 14'sd1;
            end else if (!mb_ff[52]) begin
               mb_in = {mb_ff[51:0], 1'b0};
               eb_in = eb_ff - 14'sd1;
            end else begin
               rem_in   = {1'b0, ma_ff};
               cnt_in   = 6'd0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            quo_in = {quo_ff[54:0], qbit};
            rem_in = qbit ? {rem_diff[52:0], 1'b0} : {rem_ff[52:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd55) begin
               sig_in    = {quo_ff[54:0], qbit, {(SIG_W-56){1'b0}}};
               exp_in    = ea_ff - eb_ff;
               sticky_in = qbit ? (rem_diff != 54'd0) : (rem_ff != 54'd0);
               state_in  = F_NORM;
            end
         end
         F_NORM: begin
            if (sig_ff == '0 || sig_ff[SIG_W-1]) begin
               state_in = F_SHIFT;
            end else if (sig_ff[SIG_W-1 -: 8] == 8'd0) begin
               sig_in = sig_ff << 8;
               exp_in = exp_ff - 14'sd8;
            end else begin
               sig_in = sig_ff << 1;
               exp_in = exp_ff - 14'sd1;
            end
         end
         F_SHIFT: begin
            // Results below the normal range are denormalized here.
            if (exp_ff < -14'sd1022) begin
               exp_in = -14'sd1022;
               if (shamt > 14'sd106) begin
                  sig_in    = '0;
                  sticky_in = sticky_ff | (|sig_ff);
               end else begin
                  sig_in    = sig_ff >> shamt[6:0];
                  sticky_in = sticky_ff |
                              (|(sig_ff & ~({SIG_W{1'b1}} << shamt[6:0])));
               end
            end
            state_in = F_ROUND;
         end
         F_ROUND: begin
            if (!m_up[53] && !m_up[52]) begin
               res_in = {sign_ff, 11'd0, frac_r};
            end else if (ef_r >= 14'sd2047) begin
               res_in = {sign_ff, 11'h7FF, 52'd0};
            end else begin
               res_in = {sign_ff, ef_r[10:0], frac_r};
            end
            state_in = F_DONE;
         end
         F_DONE: begin
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign rsp.done   = (state_ff == F_DONE);
   assign rsp.result = res_ff;

endmodule

FILE: design/lagrange_interpolation_13pt.sv
`timescale 1ns / 1ps

// Lagrange interpolation through thirteen fixed nodes, in IEEE double.
// The request channel (req_) carries one word per sample point; tdata holds
// the double bit pattern of the abscissa. The response channel (rsp_)
// returns one word per request with the double bit pattern of the
// polynomial value. A word moves when tvalid and tready are both high.
// All arithmetic runs on one shared add/multiply/divide unit under a small
// sequencer, so a request is taken only while the block is idle. The
// numerator chains dominate: per node, twelve subtracts and multiplies, one
// divide (one quotient bit per cycle) and a weight multiply and add.
// After reset the block first converts the node abscissae and forms the
// constant divisors on the same unit, with req_tready low. A finished
// result sits in an output register; a new request is accepted even while
// that word waits, and the sequencer only holds at the very end of the
// next request if the receiver still stalls.
module lagrange_interpolation_13pt import lgi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] sample_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [63:0] interpolated_value
);

   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff, rsp_data_in;
   logic [63:0]      p_ff, p_in;
   logic [63:0]      xi_ff, xi_in;
   logic [63:0]      prod_ff, prod_in;
   logic [63:0]      t_ff, t_in;
   logic [63:0]      acc_ff, acc_in;

   // Node abscissae and divisors, filled once after reset.
   logic [63:0]      xs_ff [NODE_COUNT];
   logic [63:0]      den_ff [NODE_COUNT];
   logic             xs_we, den_we;
   logic [IDX_W-1:0] xs_idx;
   logic [63:0]      xs_rd;

   fpu_req_type      fpu_req;
   fpu_rsp_type      fpu_rsp;
   logic             want;

   lgi_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .req   (fpu_req),
      .rsp   (fpu_rsp)
   );

   assign xs_rd = xs_ff[xs_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_X;
         k_ff         <= '0;
         i_ff         <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      p_ff        <= p_in;
      xi_ff       <= xi_in;
      prod_ff     <= prod_in;
      t_ff        <= t_in;
      acc_ff      <= acc_in;
      if (xs_we) begin
         xs_ff[k_ff[IDX_W-1:0]] <= fpu_rsp.result;
      end
      if (den_we) begin
         den_ff[i_ff] <= prod_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      rsp_data_in  = rsp_data_ff;
      p_in         = p_ff;
      xi_in        = xi_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      xs_we        = 1'b0;
      den_we       = 1'b0;
      xs_idx       = k_ff[IDX_W-1:0];
      want         = 1'b0;
      fpu_req.op   = FOP_ADD;
      fpu_req.a    = acc_ff;
      fpu_req.b    = t_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         S_INIT_X: begin
            // Each abscissa is its value in hundredths divided by one hundred.
            want       = 1'b1;
            fpu_req.op = FOP_DIV;
            fpu_req.a  = NODE_XC_BITS[k_ff[IDX_W-1:0]];
            fpu_req.b  = HUNDRED_BITS;
            if (fpu_rsp.done) begin
               xs_we = 1'b1;
               if (k_ff == CNT_W'(NODE_COUNT - 1)) begin
                  i_in     = '0;
                  state_in = S_DEN_XI;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_DEN_XI: begin
            xs_idx   = i_ff;
            xi_in    = xs_rd;
            prod_in  = ONE_BITS;
            k_in     = '0;
            state_in = S_DEN_SUB;
         end
         S_DEN_SUB: begin
            if (k_ff == CNT_W'(NODE_COUNT)) begin
               den_we = 1'b1;
               if (i_ff == IDX_W'(NODE_COUNT - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_DEN_XI;
               end
            end else if (k_ff == CNT_W'(i_ff)) begin
               k_in = k_ff + 1'b1;
            end else begin
               want       = 1'b1;
               fpu_req.op = FOP_SUB;
               fpu_req.a  = xi_ff;
               fpu_req.b  = xs_rd;
               if (fpu_rsp.done) begin
                  t_in     = fpu_rsp.result;
                  state_in = S_DEN_MUL;
               end
            end
         end
         S_DEN_MUL: begin
            want       = 1'b1;
            fpu_req.op = FOP_MUL;
            fpu_req.a  = prod_ff;
            fpu_req.b  = t_ff;
            if (fpu_rsp.done) begin
               prod_in  = fpu_rsp.result;
               k_in     = k_ff + 1'b1;
               state_in = S_DEN_SUB;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               p_in     = req_tdata;
               acc_in   = '0;
               i_in     = '0;
               state_in = S_RUN_START;
            end
         end
         S_RUN_START: begin
            prod_in  = ONE_BITS;
            k_in     = '0;
            state_in = S_RUN_SUB;
         end
         S_RUN_SUB: begin
            if (k_ff == CNT_W'(NODE_COUNT)) begin
               state_in = S_RUN_DIV;
            end else if (k_ff == CNT_W'(i_ff)) begin
               k_in = k_ff + 1'b1;
            end else begin
               want       = 1'b1;
               fpu_req.op = FOP_SUB;
               fpu_req.a  = p_ff;
               fpu_req.b  = xs_rd;
               if (fpu_rsp.done) begin
                  t_in     = fpu_rsp.result;
                  state_in = S_RUN_MUL;
               end
            end
         end
         S_RUN_MUL: begin
            want       = 1'b1;
            fpu_req.op = FOP_MUL;
            fpu_req.a  = prod_ff;
            fpu_req.b  = t_ff;
            if (fpu_rsp.done) begin
               prod_in  = fpu_rsp.result;
               k_in     = k_ff + 1'b1;
               state_in = S_RUN_SUB;
            end
         end
         S_RUN_DIV: begin
            want       = 1'b1;
            fpu_req.op = FOP_DIV;
            fpu_req.a  = prod_ff;
            fpu_req.b  = den_ff[i_ff];
            if (fpu_rsp.done) begin
               t_in     = fpu_rsp.result;
               state_in = S_RUN_WY;
            end
         end
         S_RUN_WY: begin
            want       = 1'b1;
            fpu_req.op = FOP_MUL;
            fpu_req.a  = NODE_Y_BITS[i_ff];
            fpu_req.b  = t_ff;
            if (fpu_rsp.done) begin
               t_in     = fpu_rsp.result;
               state_in = S_RUN_ACC;
            end
         end
         S_RUN_ACC: begin
            want       = 1'b1;
            fpu_req.op = FOP_ADD;
            fpu_req.a  = acc_ff;
            fpu_req.b  = t_ff;
            if (fpu_rsp.done) begin
               acc_in = fpu_rsp.result;
               if (i_ff == IDX_W'(NODE_COUNT - 1)) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_RUN_START;
               end
            end
         end
         S_DONE: begin
            // Hand the sum to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // An operation is issued once; the unit answers with a done pulse.
      fpu_req.start = want & ~busy_ff;
      if (fpu_req.start) begin
         busy_in = 1'b1;
      end else if (fpu_rsp.done) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
